FILE: design/assert_macros.svh
// Assertion macros shared by the grid shortest-path design.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define GSP_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define GSP_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define GSP_ASSERT_IMP(lbl, pre, post)
`define GSP_ASSERT_NXT(lbl, pre, post)
`endif
`endif

FILE: design/gsp_pkg.sv
// Types, constants and edge helpers for the grid shortest-path block.
// Used by the memories and the top level; depends on nothing.
package gsp_pkg;

    localparam int GRID_DIM  = 64;
    localparam int COORD_W   = 6;
    localparam int CELL_W    = 12;
    localparam int CELLS     = GRID_DIM * GRID_DIM;
    localparam int DIST_W    = 22;
    localparam int PRED_W    = 5;
    localparam int CNT_W     = 13;
    localparam int DIM_W     = 7;
    localparam int FRAC_BITS = 8;

    localparam logic [DIST_W-1:0] DIST_INF    = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAXFIN = DIST_INF - 1'b1;
    localparam logic [PRED_W-1:0] NO_PRED     = 5'd16;

    // Operation codes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               pathable;
    } gsp_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [PRED_W-1:0] pred_dir;
        logic              reachable;
        logic [CNT_W-1:0]  reached_count;
        logic              bad_cell;
    } gsp_out_t;

    // One entry of the path memory.
    typedef struct packed {
        logic              settled;
        logic [PRED_W-1:0] pred;
        logic [DIST_W-1:0] dist_val;
    } path_word_t;

    localparam int PATH_W = $bits(path_word_t);

    // Integer square root, evaluated at elaboration only.
    function automatic logic [31:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] b;
        r   = '0;
        rem = v;
        for (int k = 31; k >= 0; k--) begin
            b = 64'd1 << (2 * k);
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
        end
        return r[31:0];
    endfunction

    localparam logic [31:0] S2 = isqrt(64'd2 << (2 * FRAC_BITS + 2));
    localparam logic [31:0] S5 = isqrt(64'd5 << (2 * FRAC_BITS + 2));
    localparam logic [DIST_W-1:0] W_ORTH = DIST_W'(1) << FRAC_BITS;
    localparam logic [DIST_W-1:0] W_DIAG = DIST_W'((S2 + 32'd1) >> 1);
    localparam logic [DIST_W-1:0] W_KNGT = DIST_W'((S5 + 32'd1) >> 1);

    // Neighbor offsets, indexed by direction.
    localparam logic signed [2:0] OFF_X [16] = '{
        3'sd0, 3'sd1, 3'sd0, -3'sd1, 3'sd1, 3'sd1, -3'sd1, -3'sd1,
        3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1};
    localparam logic signed [2:0] OFF_Y [16] = '{
        3'sd1, 3'sd0, -3'sd1, 3'sd0, 3'sd1, -3'sd1, -3'sd1, 3'sd1,
        3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1, 3'sd1, 3'sd2};

    function automatic logic [DIST_W-1:0] edge_weight(input logic [3:0] i);
        logic [DIST_W-1:0] w;
        if (!i[3] && !i[2]) w = W_ORTH;
        else if (!i[3])     w = W_DIAG;
        else                w = W_KNGT;
        return w;
    endfunction

    // Direction seen from the neighbor back to the cell.
    function automatic logic [3:0] back_dir(input logic [3:0] i);
        logic [3:0] d;
        if (!i[3]) d = {1'b0, i[2], 2'(i[1:0] + 2'd2)};
        else       d = {i[3], ~i[2], i[1:0]};
        return d;
    endfunction

    // Pathable bit of the 5x5 window around the cell at offset (dx,dy).
    function automatic logic win_at(input logic [24:0] win, input int dx, input int dy);
        logic [4:0] k;
        k = 5'((dy + 2) * 5 + dx + 2);
        return win[k];
    endfunction

    // Edge test for one direction; a knight jump also needs both cells
    // along its long axis to be pathable.
    function automatic logic edge_ok(input logic [24:0] win, input logic [3:0] i);
        int   dx;
        int   dy;
        int   s;
        logic ok;
        dx = int'(OFF_X[i]);
        dy = int'(OFF_Y[i]);
        ok = win_at(win, dx, dy);
        if (i[3]) begin
            if (dy == 2 || dy == -2) begin
                s  = (dy > 0) ? 1 : -1;
                ok = ok & win_at(win, 0, s) & win_at(win, dx, s);
            end
            else begin
                s  = (dx > 0) ? 1 : -1;
                ok = ok & win_at(win, s, 0) & win_at(win, s, dy);
            end
        end
        return ok;
    endfunction

endpackage

FILE: design/gsp_walk_ram.sv
// Walk map memory: one pathable bit per cell, registered read.
// Depends on gsp_pkg.
module gsp_walk_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [gsp_pkg::CELL_W-1:0] waddr,
    input  logic                       wdata,
    input  logic [gsp_pkg::CELL_W-1:0] raddr,
    output logic                       rdata
);

    logic mem [gsp_pkg::CELLS];
    logic rdata_reg;

    // Single write port and single read port, read data registered for the next cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/gsp_path_ram.sv
// Path memory: settled flag, predecessor and distance per cell.
// Depends on gsp_pkg.
module gsp_path_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [gsp_pkg::CELL_W-1:0] waddr,
    input  gsp_pkg::path_word_t        wdata,
    input  logic [gsp_pkg::CELL_W-1:0] raddr,
    output gsp_pkg::path_word_t        rdata
);

    gsp_pkg::path_word_t mem [gsp_pkg::CELLS];
    gsp_pkg::path_word_t rdata_reg;

    // Single write port and single read port, read data registered for the next cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/grid_shortest_path_16_neighbor.sv
// Top level: sequencer for load, run and query over the walk and path memories.
// Depends on gsp_pkg, gsp_walk_ram, gsp_path_ram and assert_macros.svh.
//
//  Channel | Signals                               | Beat
//  --------+---------------------------------------+-------------------------
//  in      | in_valid, in_stall, in_item           | one op: load, run, query
//  out     | out_valid, out_stall, out_item        | one result per op
//  cfg     | cfg_we, cfg_index, cfg_data           | one register write
//
// A load passes through the load and done states, a query through the query
// read, query data and done states. A run checks the source, clears the path
// memory, then for every cell it settles it scans the grid, fetches the 5x5
// window and relaxes the 16 neighbors, and ends with one final scan.
// After reset a pass over all cells clears the walk map; no beat is taken then.
// The next input beat is taken while a finished result waits on out_stall.
`include "assert_macros.svh"

module grid_shortest_path_16_neighbor (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  gsp_pkg::gsp_in_t          in_item,
    output logic                      out_valid,
    input  logic                      out_stall,
    output gsp_pkg::gsp_out_t         out_item,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [gsp_pkg::DIM_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_LOAD, ST_RUN_CHK, ST_RUN_SRC, ST_CLR, ST_SRC_WR,
        ST_SCAN, ST_SCAN_LAST, ST_PICK, ST_WIN, ST_WIN_LAST, ST_REL_RD,
        ST_REL_UP, ST_Q_RD, ST_Q_DAT, ST_DONE
    } state_t;

    localparam logic [gsp_pkg::DIM_W-1:0] DIM_MAX = gsp_pkg::DIM_W'(gsp_pkg::GRID_DIM);

    state_t                           state_reg;
    logic [gsp_pkg::DIM_W-1:0]        width_reg;
    logic [gsp_pkg::DIM_W-1:0]        height_reg;
    gsp_pkg::gsp_in_t                 item_reg;
    gsp_pkg::gsp_out_t                res_reg;
    gsp_pkg::gsp_out_t                out_item_reg;
    logic                             out_valid_reg;
    logic                             ran_reg;
    logic                             src_ok_reg;
    logic [gsp_pkg::CELL_W-1:0]       clr_reg;
    logic [gsp_pkg::COORD_W-1:0]      sx_reg;
    logic [gsp_pkg::COORD_W-1:0]      sy_reg;
    logic                             scan_vld_reg;
    logic [gsp_pkg::CELL_W-1:0]       scan_idx_reg;
    logic                             best_found_reg;
    logic [gsp_pkg::CELL_W-1:0]       best_idx_reg;
    gsp_pkg::path_word_t              best_word_reg;
    logic [gsp_pkg::CNT_W-1:0]        cnt_reg;
    logic [2:0]                       wx_reg;
    logic [2:0]                       wy_reg;
    logic [4:0]                       wpos_reg;
    logic                             win_vld_reg;
    logic [4:0]                       win_pos_reg;
    logic                             win_in_reg;
    logic [24:0]                      win_reg;
    logic [3:0]                       nb_reg;

    logic [gsp_pkg::DIM_W-1:0]        eff_w;
    logic [gsp_pkg::DIM_W-1:0]        eff_h;
    logic                             in_grid_new;
    logic [gsp_pkg::CELL_W-1:0]       item_idx;
    logic                             scan_last;
    logic                             scan_hit;
    logic [7:0]                       nx;
    logic [7:0]                       ny;
    logic                             n_in;
    logic [gsp_pkg::COORD_W-1:0]      ux;
    logic [gsp_pkg::COORD_W-1:0]      uy;
    logic [gsp_pkg::CELL_W-1:0]       v_idx;
    logic                             nb_ok;
    logic [gsp_pkg::DIST_W:0]         nd_sum;
    logic [gsp_pkg::DIST_W-1:0]       nd;
    logic                             relax_win;

    logic                             walk_we;
    logic [gsp_pkg::CELL_W-1:0]       walk_waddr;
    logic                             walk_wdata;
    logic [gsp_pkg::CELL_W-1:0]       walk_raddr;
    logic                             walk_rdata;
    logic                             path_we;
    logic [gsp_pkg::CELL_W-1:0]       path_waddr;
    gsp_pkg::path_word_t              path_wdata;
    logic [gsp_pkg::CELL_W-1:0]       path_raddr;
    gsp_pkg::path_word_t              path_rdata;

    gsp_walk_ram u_walk (
        .clk   (clk),
        .we    (walk_we),
        .waddr (walk_waddr),
        .wdata (walk_wdata),
        .raddr (walk_raddr),
        .rdata (walk_rdata)
    );

    gsp_path_ram u_path (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr),
        .wdata (path_wdata),
        .raddr (path_raddr),
        .rdata (path_rdata)
    );

    // Grid extent in use, clamped to the memory size.
    assign eff_w = (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
    assign eff_h = (height_reg > DIM_MAX) ? DIM_MAX : height_reg;

    assign in_grid_new = ({1'b0, in_item.cell_x} < eff_w) && ({1'b0, in_item.cell_y} < eff_h);
    assign item_idx    = {item_reg.cell_y, item_reg.cell_x};

    // Scan bookkeeping.
    assign scan_last = ({1'b0, sx_reg} == eff_w - 1'b1) && ({1'b0, sy_reg} == eff_h - 1'b1);
    assign scan_hit  = scan_vld_reg && !path_rdata.settled
                       && (path_rdata.dist_val != gsp_pkg::DIST_INF)
                       && (!best_found_reg || (path_rdata.dist_val < best_word_reg.dist_val));

    // Window cell under fetch, relative to the settled cell.
    assign ux   = best_idx_reg[gsp_pkg::COORD_W-1:0];
    assign uy   = best_idx_reg[gsp_pkg::CELL_W-1:gsp_pkg::COORD_W];
    assign nx   = {2'b00, ux} + {5'd0, wx_reg} - 8'd2;
    assign ny   = {2'b00, uy} + {5'd0, wy_reg} - 8'd2;
    assign n_in = !nx[7] && !ny[7] && (nx[6:0] < eff_w) && (ny[6:0] < eff_h);

    // Relaxation of one neighbor.
    assign v_idx = {6'(uy + {{3{gsp_pkg::OFF_Y[nb_reg][2]}}, gsp_pkg::OFF_Y[nb_reg]}),
                    6'(ux + {{3{gsp_pkg::OFF_X[nb_reg][2]}}, gsp_pkg::OFF_X[nb_reg]})};
    assign nb_ok     = gsp_pkg::edge_ok(win_reg, nb_reg);
    assign nd_sum    = {1'b0, best_word_reg.dist_val} + {1'b0, gsp_pkg::edge_weight(nb_reg)};
    assign nd        = (nd_sum > {1'b0, gsp_pkg::DIST_MAXFIN}) ? gsp_pkg::DIST_MAXFIN
                                                               : nd_sum[gsp_pkg::DIST_W-1:0];
    assign relax_win = nd < path_rdata.dist_val;

    // Walk map port control.
    always_comb
    begin
        walk_we    = 1'b0;
        walk_waddr = clr_reg;
        walk_wdata = 1'b0;
        walk_raddr = item_idx;
        unique case (state_reg)
            ST_INIT:
            begin
                walk_we = 1'b1;
            end
            ST_LOAD:
            begin
                walk_we    = 1'b1;
                walk_waddr = item_idx;
                walk_wdata = item_reg.pathable;
            end
            ST_WIN:
            begin
                walk_raddr = {ny[5:0], nx[5:0]};
            end
            default:
            begin
                walk_we = 1'b0;
            end
        endcase
    end

    // Path memory port control.
    always_comb
    begin
        path_we    = 1'b0;
        path_waddr = clr_reg;
        path_wdata = '{settled: 1'b0, pred: gsp_pkg::NO_PRED, dist_val: gsp_pkg::DIST_INF};
        path_raddr = item_idx;
        unique case (state_reg)
            ST_CLR:
            begin
                path_we = 1'b1;
            end
            ST_SRC_WR:
            begin
                path_we    = 1'b1;
                path_waddr = item_idx;
                path_wdata = '{settled: 1'b0, pred: gsp_pkg::NO_PRED, dist_val: '0};
            end
            ST_SCAN:
            begin
                path_raddr = {sy_reg, sx_reg};
            end
            ST_PICK:
            begin
                path_we    = best_found_reg;
                path_waddr = best_idx_reg;
                path_wdata = '{settled: 1'b1, pred: best_word_reg.pred,
                               dist_val: best_word_reg.dist_val};
            end
            ST_REL_RD:
            begin
                path_raddr = v_idx;
            end
            ST_REL_UP:
            begin
                path_we    = relax_win;
                path_waddr = v_idx;
                path_wdata = '{settled: path_rdata.settled,
                               pred: {1'b0, gsp_pkg::back_dir(nb_reg)}, dist_val: nd};
            end
            default:
            begin
                path_we = 1'b0;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Sequencer, configuration registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            width_reg      <= DIM_MAX;
            height_reg     <= DIM_MAX;
            item_reg       <= '0;
            res_reg        <= '0;
            out_item_reg   <= '0;
            out_valid_reg  <= 1'b0;
            ran_reg        <= 1'b0;
            src_ok_reg     <= 1'b0;
            clr_reg        <= '0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            scan_vld_reg   <= 1'b0;
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_word_reg  <= '0;
            cnt_reg        <= '0;
            wx_reg         <= '0;
            wy_reg         <= '0;
            wpos_reg       <= '0;
            win_vld_reg    <= 1'b0;
            win_pos_reg    <= '0;
            win_in_reg     <= 1'b0;
            win_reg        <= '0;
            nb_reg         <= '0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gsp_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    gsp_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                endcase
            end

            // Output beat leaves when the receiver takes it; the done state
            // refills the register itself in that cycle.
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // Scan read pipeline and best-cell tracking.
            scan_vld_reg <= (state_reg == ST_SCAN);
            scan_idx_reg <= {sy_reg, sx_reg};
            if (scan_hit)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= scan_idx_reg;
                best_word_reg  <= path_rdata;
            end

            // Window read pipeline.
            win_vld_reg <= (state_reg == ST_WIN);
            win_pos_reg <= wpos_reg;
            win_in_reg  <= n_in;
            if (win_vld_reg)
            begin
                win_reg[win_pos_reg] <= walk_rdata & win_in_reg;
            end

            unique case (state_reg)
                ST_INIT:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_item;
                        // Outside-grid loads and queries are answered at once.
                        res_reg  <= '{distance: (in_item.op == gsp_pkg::OP_QUERY && !in_grid_new)
                                                ? gsp_pkg::DIST_INF
                                                : {gsp_pkg::DIST_W{1'b0}},
                                      pred_dir: gsp_pkg::NO_PRED,
                                      reachable: 1'b0, reached_count: '0,
                                      bad_cell: (in_item.op == gsp_pkg::OP_LOAD
                                                 || in_item.op == gsp_pkg::OP_QUERY)
                                                && !in_grid_new};
                        priority case (in_item.op)
                            gsp_pkg::OP_LOAD:
                            begin
                                if (in_grid_new)
                                begin
                                    state_reg <= ST_LOAD;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            gsp_pkg::OP_RUN:
                            begin
                                src_ok_reg <= in_grid_new;
                                state_reg  <= ST_RUN_CHK;
                            end
                            gsp_pkg::OP_QUERY:
                            begin
                                if (in_grid_new)
                                begin
                                    state_reg <= ST_Q_RD;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_DONE;
                end
                ST_RUN_CHK:
                begin
                    state_reg <= ST_RUN_SRC;
                end
                ST_RUN_SRC:
                begin
                    src_ok_reg <= src_ok_reg & walk_rdata;
                    clr_reg    <= '0;
                    state_reg  <= ST_CLR;
                end
                ST_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        ran_reg <= 1'b1;
                        if (src_ok_reg)
                        begin
                            state_reg <= ST_SRC_WR;
                        end
                        else
                        begin
                            res_reg.bad_cell <= 1'b1;
                            state_reg        <= ST_DONE;
                        end
                    end
                end
                ST_SRC_WR:
                begin
                    cnt_reg        <= '0;
                    sx_reg         <= '0;
                    sy_reg         <= '0;
                    best_found_reg <= 1'b0;
                    state_reg      <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= ST_SCAN_LAST;
                    end
                    else if ({1'b0, sx_reg} == eff_w - 1'b1)
                    begin
                        sx_reg <= '0;
                        sy_reg <= sy_reg + 1'b1;
                    end
                    else
                    begin
                        sx_reg <= sx_reg + 1'b1;
                    end
                end
                ST_SCAN_LAST:
                begin
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (best_found_reg)
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        wx_reg    <= '0;
                        wy_reg    <= '0;
                        wpos_reg  <= '0;
                        state_reg <= ST_WIN;
                    end
                    else
                    begin
                        res_reg.reached_count <= cnt_reg;
                        state_reg             <= ST_DONE;
                    end
                end
                ST_WIN:
                begin
                    wpos_reg <= wpos_reg + 1'b1;
                    if (wx_reg == 3'd4)
                    begin
                        wx_reg <= '0;
                        wy_reg <= wy_reg + 1'b1;
                    end
                    else
                    begin
                        wx_reg <= wx_reg + 1'b1;
                    end
                    if (wpos_reg == 5'd24)
                    begin
                        state_reg <= ST_WIN_LAST;
                    end
                end
                ST_WIN_LAST:
                begin
                    nb_reg    <= '0;
                    state_reg <= ST_REL_RD;
                end
                ST_REL_RD:
                begin
                    if (nb_ok)
                    begin
                        state_reg <= ST_REL_UP;
                    end
                    else if (&nb_reg)
                    begin
                        sx_reg         <= '0;
                        sy_reg         <= '0;
                        best_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                    else
                    begin
                        nb_reg <= nb_reg + 1'b1;
                    end
                end
                ST_REL_UP:
                begin
                    if (&nb_reg)
                    begin
                        sx_reg         <= '0;
                        sy_reg         <= '0;
                        best_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                    else
                    begin
                        nb_reg    <= nb_reg + 1'b1;
                        state_reg <= ST_REL_RD;
                    end
                end
                ST_Q_RD:
                begin
                    state_reg <= ST_Q_DAT;
                end
                ST_Q_DAT:
                begin
                    if (ran_reg)
                    begin
                        res_reg.distance  <= path_rdata.dist_val;
                        res_reg.pred_dir  <= path_rdata.pred;
                        res_reg.reachable <= (path_rdata.dist_val != gsp_pkg::DIST_INF);
                    end
                    else
                    begin
                        res_reg.distance <= gsp_pkg::DIST_INF;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_item_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // An accepted beat always leaves the idle state.
    `GSP_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_reg != ST_IDLE)
    // The minimum search never writes the path memory.
    `GSP_ASSERT_IMP(a_scan_no_write, state_reg == ST_SCAN, !path_we)
    // The cell picked for settling was not settled before.
    `GSP_ASSERT_IMP(a_pick_unsettled, state_reg == ST_PICK && best_found_reg,
                    !best_word_reg.settled)
    // The settled count never exceeds the number of cells.
    `GSP_ASSERT_IMP(a_count_bound, state_reg != ST_INIT,
                    cnt_reg <= gsp_pkg::CNT_W'(gsp_pkg::CELLS))

endmodule
